[design/ile_pkg.sv]
// shared types and constants for the indexed list engine
// no dependencies

package ile_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = 5;
    localparam int POS_W    = 5;
    localparam int VAL_W    = 32;
    localparam int REQ_W    = 2;
    localparam int STAT_W   = 2;
    localparam int IN_W     = 40;
    localparam int OUT_W    = 40;

    typedef enum logic [REQ_W-1:0] {
        REQ_READ   = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_APPEND = 2'd2,
        REQ_DELETE = 2'd3
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // broadcast to every cell of the row
    typedef struct packed {
        logic             ins;
        logic             del;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] value;
    } cell_op_t;

endpackage

[design/ile_cell.sv]
// one storage cell of the list row, shifts towards either neighbour
// depends on ile_pkg

module ile_cell
(
    input  logic                        clk,
    input  logic [ile_pkg::IDX_W-1:0]   cell_index,
    input  ile_pkg::cell_op_t           op,
    input  logic [ile_pkg::VAL_W-1:0]   prev_value,
    input  logic [ile_pkg::VAL_W-1:0]   next_value,
    output logic [ile_pkg::VAL_W-1:0]   entry
);

    logic [ile_pkg::VAL_W-1:0] entry_reg;
    logic [ile_pkg::VAL_W-1:0] entry_next;
    logic [ile_pkg::POS_W-1:0] my_pos;

    assign my_pos = ile_pkg::POS_W'(cell_index);

    always_comb
    begin
        entry_next = entry_reg;
        if (op.ins && (my_pos == op.pos))
        begin
            entry_next = op.value;
        end
        else if (op.ins && (my_pos > op.pos))
        begin
            entry_next = prev_value;
        end
        else if (op.del && (my_pos >= op.pos))
        begin
            entry_next = next_value;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

[design/indexed_list_engine_core.sv]
// indexed list engine: request decode, row of shifting cells, result register
// one item per cycle while m_tready does not hold the result register, result in the cycle after acceptance
// reset clears the entry count and the result register, cell contents are unknown
// depends on ile_pkg and ile_cell

module indexed_list_engine_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // req_type[1:0], position[6:2], value[38:7], zero fill
    input  logic [ile_pkg::IN_W-1:0]    s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // read_value[31:0], status[33:32], count[38:34], zero fill
    output logic [ile_pkg::OUT_W-1:0]   m_tdata
);

    logic [ile_pkg::CNT_W-1:0]  count_reg;
    logic [ile_pkg::CNT_W-1:0]  count_next;
    logic                       out_valid_reg;
    logic [ile_pkg::OUT_W-1:0]  out_data_reg;
    logic [ile_pkg::OUT_W-1:0]  out_data_next;

    logic                       accept;
    ile_pkg::req_t              req;
    logic [ile_pkg::POS_W-1:0]  pos;
    logic [ile_pkg::VAL_W-1:0]  value;
    logic                       full;
    logic [ile_pkg::VAL_W-1:0]  rd;
    ile_pkg::status_t           st;
    ile_pkg::cell_op_t          op;

    logic [ile_pkg::VAL_W-1:0]  cell_value [ile_pkg::CAPACITY];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign req   = ile_pkg::req_t'(s_tdata[1:0]);
    assign pos   = s_tdata[6:2];
    assign value = s_tdata[38:7];
    assign full  = (count_reg == ile_pkg::CNT_W'(ile_pkg::CAPACITY));

    always_comb
    begin
        rd         = '0;
        st         = ile_pkg::ST_DONE;
        count_next = count_reg;
        op.ins     = 1'b0;
        op.del     = 1'b0;
        op.pos     = pos;
        op.value   = value;
        case (req)
            ile_pkg::REQ_READ:
            begin
                if (pos < count_reg)
                begin
                    rd = cell_value[pos[ile_pkg::IDX_W-1:0]];
                end
                else
                begin
                    rd = '1;
                    st = ile_pkg::ST_RANGE;
                end
            end
            ile_pkg::REQ_INSERT:
            begin
                if (pos > count_reg)
                begin
                    st = ile_pkg::ST_RANGE;
                end
                else if (full)
                begin
                    st = ile_pkg::ST_FULL;
                end
                else
                begin
                    op.ins     = accept;
                    count_next = count_reg + 1'b1;
                end
            end
            ile_pkg::REQ_APPEND:
            begin
                op.pos = count_reg;
                if (full)
                begin
                    st = ile_pkg::ST_FULL;
                end
                else
                begin
                    op.ins     = accept;
                    count_next = count_reg + 1'b1;
                end
            end
            ile_pkg::REQ_DELETE:
            begin
                if (pos >= count_reg)
                begin
                    st = ile_pkg::ST_RANGE;
                end
                else
                begin
                    op.del     = accept;
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                st = ile_pkg::ST_RANGE;
            end
        endcase
        out_data_next = {1'b0, count_next, st, rd};
    end

    genvar gi;
    generate
        for (gi = 0; gi < ile_pkg::CAPACITY; gi++)
        begin : g_cell
            logic [ile_pkg::VAL_W-1:0] prev_v;
            logic [ile_pkg::VAL_W-1:0] next_v;
            if (gi == 0)
            begin : g_head
                assign prev_v = '0;
            end
            else
            begin : g_prev
                assign prev_v = cell_value[gi-1];
            end
            if (gi == ile_pkg::CAPACITY - 1)
            begin : g_tail
                assign next_v = '0;
            end
            else
            begin : g_next
                assign next_v = cell_value[gi+1];
            end
            ile_cell u_cell
            (
                .clk        (clk),
                .cell_index (ile_pkg::IDX_W'(gi)),
                .op         (op),
                .prev_value (prev_v),
                .next_value (next_v),
                .entry      (cell_value[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
                out_data_reg  <= out_data_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

[tb/tb.sv]
// testbench for indexed_list_engine_core: directed table then random list traffic
// results checked field by field against the directed table or an in-bench list model
// depends on ile_pkg and the indexed_list_engine_core rtl

`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        logic [ile_pkg::CNT_W-1:0] cnt;
        ile_pkg::status_t          st;
        logic [ile_pkg::VAL_W-1:0] rd;
    } list_result_t;

    typedef struct packed {
        ile_pkg::req_t             req;
        logic [ile_pkg::POS_W-1:0] pos;
        logic [ile_pkg::VAL_W-1:0] val;
        logic [4:0]                reps;
        logic                      typed;
        list_result_t              res;
    } list_step_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [ile_pkg::IN_W-1:0]   s_tdata = '0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [ile_pkg::OUT_W-1:0]  m_tdata;

    logic [ile_pkg::VAL_W-1:0]  cells [ile_pkg::CAPACITY];
    int                         held = 0;
    list_result_t               pending_answers [$];
    int                         fail_count = 0;
    int                         sender_idle_pct = 0;
    int                         recv_stall_pct = 0;

    int idle_by_phase  [4] = '{0, 65, 0, 19};
    int stall_by_phase [4] = '{0, 0, 65, 19};

    list_step_t directed_steps [24] = '{
        '{req: ile_pkg::REQ_READ,   pos: 5'd0,  val: 32'd0,         reps: 5'd1, typed: 1'b1,
          res: '{cnt: 5'd0,  st: ile_pkg::ST_RANGE, rd: 32'hFFFF_FFFF}},
        '{req: ile_pkg::REQ_DELETE, pos: 5'd0,  val: 32'd0,         reps: 5'd1, typed: 1'b1,
          res: '{cnt: 5'd0,  st: ile_pkg::ST_RANGE, rd: 32'd0}},
        '{req: ile_pkg::REQ_INSERT, pos: 5'd1,  val: 32'd1,         reps: 5'd1, typed: 1'b1,
          res: '{cnt: 5'd0,  st: ile_pkg::ST_RANGE, rd: 32'd0}},
        '{req: ile_pkg::REQ_INSERT, pos: 5'd0,  val: 32'h7FFF_FFFF, reps: 5'd1, typed: 1'b1,
          res: '{cnt: 5'd1,  st: ile_pkg::ST_DONE,  rd: 32'd0}},
        '{req: ile_pkg::REQ_APPEND, pos: 5'd16, val: 32'h8000_0000, reps: 5'd1, typed: 1'b1,
          res: '{cnt: 5'd2,  st: ile_pkg::ST_DONE,  rd: 32'd0}},
        '{req: ile_pkg::REQ_READ,   pos: 5'd0,  val: 32'd0,         reps: 5'd1, typed: 1'b1,
          res: '{cnt: 5'd2,  st: ile_pkg::ST_DONE,  rd: 32'h7FFF_FFFF}},
        '{req: ile_pkg::REQ_READ,   pos: 5'd1,  val: 32'd0,         reps: 5'd1, typed: 1'b1,
          res: '{cnt: 5'd2,  st: ile_pkg::ST_DONE,  rd: 32'h8000_0000}},
        '{req: ile_pkg::REQ_INSERT, pos: 5'd2,  val: 32'hFFFF_FFFF, reps: 5'd1, typed: 1'b1,
          res: '{cnt: 5'd3,  st: ile_pkg::ST_DONE,  rd: 32'd0}},
        '{req: ile_pkg::REQ_INSERT, pos: 5'd1,  val: 32'd0,         reps: 5'd1, typed: 1'b0,
          res: '0},
        '{req: ile_pkg::REQ_READ,   pos: 5'd1,  val: 32'd0,         reps: 5'd1, typed: 1'b0,
          res: '0},
        '{req: ile_pkg::REQ_READ,   pos: 5'd4,  val: 32'd0,         reps: 5'd1, typed: 1'b0,
          res: '0},
        '{req: ile_pkg::REQ_DELETE, pos: 5'd0,  val: 32'd0,         reps: 5'd1, typed: 1'b0,
          res: '0},
        '{req: ile_pkg::REQ_APPEND, pos: 5'd0,  val: 32'h5555_5555, reps: 5'd16, typed: 1'b0,
          res: '0},
        '{req: ile_pkg::REQ_INSERT, pos: 5'd16, val: 32'hAAAA_AAAA, reps: 5'd1, typed: 1'b1,
          res: '{cnt: 5'd16, st: ile_pkg::ST_FULL,  rd: 32'd0}},
        '{req: ile_pkg::REQ_INSERT, pos: 5'd0,  val: 32'hAAAA_AAAA, reps: 5'd1, typed: 1'b1,
          res: '{cnt: 5'd16, st: ile_pkg::ST_FULL,  rd: 32'd0}},
        '{req: ile_pkg::REQ_APPEND, pos: 5'd0,  val: 32'hAAAA_AAAA, reps: 5'd1, typed: 1'b1,
          res: '{cnt: 5'd16, st: ile_pkg::ST_FULL,  rd: 32'd0}},
        '{req: ile_pkg::REQ_READ,   pos: 5'd15, val: 32'd0,         reps: 5'd1, typed: 1'b0,
          res: '0},
        '{req: ile_pkg::REQ_READ,   pos: 5'd16, val: 32'd0,         reps: 5'd1, typed: 1'b1,
          res: '{cnt: 5'd16, st: ile_pkg::ST_RANGE, rd: 32'hFFFF_FFFF}},
        '{req: ile_pkg::REQ_DELETE, pos: 5'd16, val: 32'd0,         reps: 5'd1, typed: 1'b1,
          res: '{cnt: 5'd16, st: ile_pkg::ST_RANGE, rd: 32'd0}},
        '{req: ile_pkg::REQ_DELETE, pos: 5'd15, val: 32'd0,         reps: 5'd1, typed: 1'b1,
          res: '{cnt: 5'd15, st: ile_pkg::ST_DONE,  rd: 32'd0}},
        '{req: ile_pkg::REQ_INSERT, pos: 5'd16, val: 32'd7,         reps: 5'd1, typed: 1'b1,
          res: '{cnt: 5'd15, st: ile_pkg::ST_RANGE, rd: 32'd0}},
        '{req: ile_pkg::REQ_DELETE, pos: 5'd0,  val: 32'd0,         reps: 5'd1, typed: 1'b0,
          res: '0},
        '{req: ile_pkg::REQ_INSERT, pos: 5'd7,  val: 32'hAAAA_AAAA, reps: 5'd1, typed: 1'b0,
          res: '0},
        '{req: ile_pkg::REQ_READ,   pos: 5'd7,  val: 32'd0,         reps: 5'd1, typed: 1'b0,
          res: '0}
    };

    indexed_list_engine_core dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void place_entry(int at, logic [ile_pkg::VAL_W-1:0] v);
        int i;
        for (i = held; i > at; i--)
            cells[i] = cells[i-1];
        cells[at] = v;
        held++;
    endfunction

    // applies one request to the shadow list and returns its result
    function automatic list_result_t list_apply(ile_pkg::req_t req,
                                                logic [ile_pkg::POS_W-1:0] pos,
                                                logic [ile_pkg::VAL_W-1:0] val);
        list_result_t r;
        int           i;
        r = '{cnt: '0, st: ile_pkg::ST_DONE, rd: '0};
        case (req)
            ile_pkg::REQ_READ:
                if (pos < held)
                    r.rd = cells[pos[ile_pkg::IDX_W-1:0]];
                else
                begin
                    r.rd = '1;
                    r.st = ile_pkg::ST_RANGE;
                end
            ile_pkg::REQ_INSERT:
                if (pos > held)
                    r.st = ile_pkg::ST_RANGE;
                else if (held >= ile_pkg::CAPACITY)
                    r.st = ile_pkg::ST_FULL;
                else
                    place_entry(pos, val);
            ile_pkg::REQ_APPEND:
                if (held >= ile_pkg::CAPACITY)
                    r.st = ile_pkg::ST_FULL;
                else
                    place_entry(held, val);
            default:
                if (pos >= held)
                    r.st = ile_pkg::ST_RANGE;
                else
                begin
                    for (i = pos; i + 1 < held; i++)
                        cells[i] = cells[i+1];
                    held--;
                end
        endcase
        r.cnt = held[ile_pkg::CNT_W-1:0];
        return r;
    endfunction

    task automatic offer_request(input ile_pkg::req_t req,
                                 input logic [ile_pkg::POS_W-1:0] pos,
                                 input logic [ile_pkg::VAL_W-1:0] val, input logic typed,
                                 input list_result_t typed_res);
        list_result_t r;
        @(negedge clk);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, val, pos, req};
        do
            @(posedge clk);
        while (!s_tready);
        r = list_apply(req, pos, val);
        pending_answers.push_back(typed ? typed_res : r);
    endtask

    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        list_result_t got;
        list_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[ile_pkg::CNT_W+ile_pkg::STAT_W+ile_pkg::VAL_W-1:0];
            if (pending_answers.size() == 0)
            begin
                $error("result item with nothing pending");
                fail_count++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (got.rd !== want.rd)
                begin
                    $error("read_value expected %0d got %0d", $signed(want.rd), $signed(got.rd));
                    fail_count++;
                end
                if (got.st !== want.st)
                begin
                    $error("status expected %0d got %0d", want.st, got.st);
                    fail_count++;
                end
                if (got.cnt !== want.cnt)
                begin
                    $error("count expected %0d got %0d", want.cnt, got.cnt);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        int                        row;
        int                        k;
        int                        ph;
        int                        n;
        bit                        grow;
        ile_pkg::req_t             req;
        logic [ile_pkg::POS_W-1:0] pos;
        logic [ile_pkg::VAL_W-1:0] val;
        grow = 1'b1;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (row = 0; row < 24; row++)
            for (k = 0; k < directed_steps[row].reps; k++)
                offer_request(directed_steps[row].req, directed_steps[row].pos,
                              directed_steps[row].val, directed_steps[row].typed,
                              directed_steps[row].res);

        for (ph = 0; ph < 4; ph++)
        begin
            sender_idle_pct = idle_by_phase[ph];
            recv_stall_pct  = stall_by_phase[ph];
            for (n = 0; n < 100; n++)
            begin
                // swing between filling and draining so full and empty are both reached
                if (held == ile_pkg::CAPACITY)
                    grow = 1'b0;
                else if (held == 0)
                    grow = 1'b1;
                k = $urandom_range(0, 99);
                if (grow)
                    req = k < 40 ? ile_pkg::REQ_INSERT : k < 70 ? ile_pkg::REQ_APPEND :
                          k < 85 ? ile_pkg::REQ_READ : ile_pkg::REQ_DELETE;
                else
                    req = k < 45 ? ile_pkg::REQ_DELETE : k < 75 ? ile_pkg::REQ_READ :
                          k < 88 ? ile_pkg::REQ_INSERT : ile_pkg::REQ_APPEND;
                if ($urandom_range(0, 9) == 0)
                    pos = ile_pkg::POS_W'($urandom_range(0, ile_pkg::CAPACITY));
                else
                    pos = ile_pkg::POS_W'($urandom_range(0, held));
                val = $urandom();
                if ($urandom_range(0, 9) == 0)
                    case ($urandom_range(0, 3))
                        0: val = 32'h0000_0000;
                        1: val = 32'hFFFF_FFFF;
                        2: val = 32'h8000_0000;
                        default: val = 32'h7FFF_FFFF;
                    endcase
                offer_request(req, pos, val, 1'b0, '0);
            end
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
